// ===== rtl/lzwd_pkg.sv =====
package lzwd_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int MAX_MATCH  = 64;
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int DIST_W     = 13;
  localparam int LEN_W      = 7;
  localparam int CNT_W      = $clog2(MAX_MATCH + 1);
  localparam int TOTAL_W    = 32;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } lzwd_state_t;

endpackage

// ===== rtl/lz77_window_decoder_core.sv =====
// LZ77 token decoder with a 4096-byte history window held in one synchronous
// RAM (one write and one registered read per cycle). Literal, error, empty and
// after-done tokens each give one word. A match gives min(copy_length, distance,
// 64) words at one word per cycle while the output is not stalled, once the first
// registered RAM read has returned. The single RAM read port sets that rate.
// stream_done reflects the byte count after each word against total_length,
// written on the cfg port; the user must write it only while idle, which the
// block itself does not enforce.
module lz77_window_decoder_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lzwd_pkg::TOTAL_W-1:0] cfg_total_length,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_is_match,
  input  logic [7:0]                   in_literal,
  input  logic [lzwd_pkg::DIST_W-1:0]  in_distance,
  input  logic [lzwd_pkg::LEN_W-1:0]   in_copy_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_data_byte,
  output logic                         out_has_byte,
  output logic                         out_end_of_run,
  output logic                         out_stream_done,
  output logic                         out_bad_offset
);
  import lzwd_pkg::*;

  localparam logic [DIST_W-1:0] HIST_DEPTH_D = DIST_W'(HIST_DEPTH);
  localparam logic [DIST_W-1:0] MAX_MATCH_D  = DIST_W'(MAX_MATCH);

  logic [7:0] hist_mem [HIST_DEPTH];

  lzwd_state_t        state_r, state_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [TOTAL_W-1:0] prod_r, prod_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]   em_cnt_r, em_cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [7:0]         rd_data_r;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_has_r, out_has_nxt;
  logic               out_eor_r, out_eor_nxt;
  logic               out_done_r, out_done_nxt;
  logic               out_bad_r, out_bad_nxt;

  logic               out_free, acc, emit, rd_en, last_emit;
  logic               done_now, too_far, start_copy;
  logic [DIST_W-1:0]  len_ext, cnt_a, cnt_b;
  logic [CNT_W-1:0]   tok_cnt;
  logic [TOTAL_W-1:0] prod_inc;
  logic               mem_we;
  logic [7:0]         mem_wd;

  // token decode
  always_comb begin
    done_now = (prod_r >= total_r);
    too_far  = (TOTAL_W'(in_distance) > prod_r) || (in_distance > HIST_DEPTH_D);
    len_ext  = DIST_W'(in_copy_length);
    cnt_a    = (len_ext > in_distance) ? in_distance : len_ext;
    cnt_b    = (cnt_a > MAX_MATCH_D) ? MAX_MATCH_D : cnt_a;
    tok_cnt  = CNT_W'(cnt_b);
    prod_inc = (prod_r == {TOTAL_W{1'b1}}) ? prod_r : prod_r + 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start_copy) state_nxt = ST_COPY;
      ST_COPY: if (emit && last_emit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    out_free   = !out_valid_r || out_ready;
    in_ready   = (state_r == ST_IDLE) && out_free;
    acc        = in_valid && in_ready;
    start_copy = acc && !done_now && in_is_match && !too_far && (tok_cnt != '0);
    emit       = (state_r == ST_COPY) && pend_r && out_free;
    last_emit  = (em_cnt_r + 1'b1) == count_r;
    rd_en      = (state_r == ST_COPY) && (rd_cnt_r != count_r) && (!pend_r || emit);
  end

  // datapath
  always_comb begin
    wp_nxt        = wp_r;
    rd_addr_nxt   = rd_addr_r;
    prod_nxt      = prod_r;
    total_nxt     = total_r;
    count_nxt     = count_r;
    rd_cnt_nxt    = rd_cnt_r;
    em_cnt_nxt    = em_cnt_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_has_nxt   = out_has_r;
    out_eor_nxt   = out_eor_r;
    out_done_nxt  = out_done_r;
    out_bad_nxt   = out_bad_r;
    mem_we        = 1'b0;
    mem_wd        = in_literal;

    if (cfg_valid && cfg_ready) total_nxt = cfg_total_length;

    if (acc) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = '0;
      out_has_nxt   = 1'b0;
      out_eor_nxt   = 1'b1;
      out_done_nxt  = done_now;
      out_bad_nxt   = 1'b0;
      priority if (done_now) begin
      end else if (!in_is_match) begin
        mem_we       = 1'b1;
        wp_nxt       = wp_r + 1'b1;
        prod_nxt     = prod_inc;
        out_byte_nxt = in_literal;
        out_has_nxt  = 1'b1;
        out_done_nxt = (prod_inc >= total_r);
      end else if (too_far) begin
        out_bad_nxt = 1'b1;
      end else if (start_copy) begin
        out_valid_nxt = 1'b0;
        rd_addr_nxt   = wp_r - PTR_W'(in_distance);
        count_nxt     = tok_cnt;
        rd_cnt_nxt    = '0;
        em_cnt_nxt    = '0;
        pend_nxt      = 1'b0;
      end else begin
      end
    end

    if (emit) begin
      mem_we        = 1'b1;
      mem_wd        = rd_data_r;
      wp_nxt        = wp_r + 1'b1;
      prod_nxt      = prod_inc;
      em_cnt_nxt    = em_cnt_r + 1'b1;
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rd_data_r;
      out_has_nxt   = 1'b1;
      out_eor_nxt   = last_emit;
      out_done_nxt  = (prod_inc >= total_r);
      out_bad_nxt   = 1'b0;
    end

    if (rd_en) begin
      rd_addr_nxt = rd_addr_r + 1'b1;
      rd_cnt_nxt  = rd_cnt_r + 1'b1;
      pend_nxt    = 1'b1;
    end
  end

  // history RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[wp_r] <= mem_wd;
    if (rd_en) rd_data_r <= hist_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      prod_r      <= '0;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      em_cnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      prod_r      <= prod_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      em_cnt_r    <= em_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    out_byte_r <= out_byte_nxt;
    out_has_r  <= out_has_nxt;
    out_eor_r  <= out_eor_nxt;
    out_done_r <= out_done_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_data_byte   = out_byte_r;
  assign out_has_byte    = out_has_r;
  assign out_end_of_run  = out_eor_r;
  assign out_stream_done = out_done_r;
  assign out_bad_offset  = out_bad_r;

endmodule
